/* hw/rtl/cmas_pkg.sv */
`timescale 1ns / 1ps

package cmas_pkg;

	localparam int RAW_W    = 20;
	localparam int OFF_W    = 21;
	localparam int GAIN_W   = 16;
	localparam int WSIZE_W  = 5;
	localparam int OUT_W    = 16;
	localparam int DIFF_W   = 22;
	localparam int GMUL_W   = 18;
	localparam int PROD_W   = 40;
	localparam int SUM_W    = 25;
	localparam int DCNT_W   = 5;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [GAIN_W:0]  GAIN_ONE  = 17'd256;
	localparam logic [RAW_W-1:0] RAW_MAX   = 20'hFFFFF;
	localparam logic [OUT_W-1:0] OUT_MAX   = 16'hFFFF;
	localparam logic [RAW_W:0]   ROUND_HALF = 21'd8;

	typedef enum logic [1:0] {
		REG_ENABLE      = 2'd0,
		REG_CAL_OFFSET  = 2'd1,
		REG_CAL_GAIN    = 2'd2,
		REG_WINDOW_SIZE = 2'd3
	} reg_idx_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_CAL  = 6'b000100,
		ST_SUM  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

endpackage

/* hw/rtl/calibrated_moving_average_sensor_top.sv */
`timescale 1ns / 1ps
// Calibrated light sensor with moving average. Each item carries one raw Q16.4
// reading; the block subtracts cal_offset, scales by the Q8.8 cal_gain (0 means
// 1.0), clamps to the Q16.4 range and, when window_size is above 1, averages it
// with the earlier values held in a ring of up to WINDOW_DEPTH entries (at most
// 31, the reach of window_size). A disabled block sends an item straight to
// output; else it is multiplied and calibrated and, with filtering, the ring is
// read one entry per cycle into an accumulator and the mean comes from a
// one-bit-per-cycle divider over 25 quotient bits. in_ready is high only between
// items; a result waits in the output register while the next item runs; that
// item stalls until the register is free. Writing window_size resets the ring
// fill; configuration must be written while idle; the block does not enforce it.

module calibrated_moving_average_sensor_top #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cmas_pkg::ADDR_W-1:0]    paddr,
	input  logic [cmas_pkg::DATA_W-1:0]    pwdata,
	output logic [cmas_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cmas_pkg::RAW_W-1:0]     raw_reading,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cmas_pkg::OUT_W-1:0]     ppfd_out,
	output logic                           status
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = (AW > cmas_pkg::WSIZE_W) ? AW + 1 : cmas_pkg::WSIZE_W + 1;

	logic                              enable_q;
	logic signed [cmas_pkg::OFF_W-1:0] cal_offset_q;
	logic [cmas_pkg::GAIN_W-1:0]       cal_gain_q;
	logic [cmas_pkg::WSIZE_W-1:0]      window_size_q;
	logic [cmas_pkg::WSIZE_W-1:0]      wsize_wr;

	cmas_pkg::state_t                  state_q;
	cmas_pkg::reg_idx_t                reg_idx;
	logic                              div_start;
	logic                              div_done;
	logic                              cfg_wr;

	logic [cmas_pkg::RAW_W-1:0]        raw_q;
	logic signed [cmas_pkg::DIFF_W-1:0] diff_c;
	logic [cmas_pkg::GAIN_W:0]         gain_eff;
	logic signed [cmas_pkg::GMUL_W-1:0] gmul_c;
	logic signed [cmas_pkg::PROD_W-1:0] prod_c;
	logic signed [cmas_pkg::PROD_W-1:0] prod_q;
	logic [cmas_pkg::RAW_W-1:0]        val_c;
	logic [cmas_pkg::RAW_W:0]          rnd_c;

	logic [cmas_pkg::RAW_W-1:0]        store [WINDOW_DEPTH];
	logic [AW-1:0]                     wi_q;
	logic                              full_q;
	logic [CW-1:0]                     wi_inc;
	logic                              wrap;
	logic [cmas_pkg::WSIZE_W-1:0]      cnt_nx;
	logic                              store_we;

	logic [cmas_pkg::WSIZE_W-1:0]      cnt_q;
	logic [cmas_pkg::WSIZE_W-1:0]      rem_q;
	logic [AW-1:0]                     rd_addr_q;
	logic                              rd_vld_s1;
	logic [cmas_pkg::RAW_W-1:0]        rd_data_s1;
	logic [cmas_pkg::SUM_W-1:0]        sum_q;
	logic [cmas_pkg::SUM_W-1:0]        quo;

	logic [cmas_pkg::OUT_W-1:0]        res_q;
	logic                              res_stat_q;
	logic [cmas_pkg::OUT_W-1:0]        ppfd_out_q;
	logic                              status_q;
	logic                              out_valid_q;
	logic                              out_load;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = cmas_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_comb begin
		wsize_wr = pwdata[cmas_pkg::WSIZE_W-1:0];
		if (int'(pwdata[cmas_pkg::WSIZE_W-1:0]) > WINDOW_DEPTH)
			wsize_wr = cmas_pkg::WSIZE_W'(WINDOW_DEPTH);
	end

	always_comb begin
		case (reg_idx)
			cmas_pkg::REG_ENABLE:      prdata = cmas_pkg::DATA_W'(enable_q);
			cmas_pkg::REG_CAL_OFFSET:  prdata = cmas_pkg::DATA_W'(cal_offset_q);
			cmas_pkg::REG_CAL_GAIN:    prdata = cmas_pkg::DATA_W'(cal_gain_q);
			cmas_pkg::REG_WINDOW_SIZE: prdata = cmas_pkg::DATA_W'(window_size_q);
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			cal_offset_q  <= '0;
			cal_gain_q    <= '0;
			window_size_q <= cmas_pkg::WSIZE_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				cmas_pkg::REG_ENABLE:      enable_q      <= pwdata[0];
				cmas_pkg::REG_CAL_OFFSET:  cal_offset_q  <= pwdata[cmas_pkg::OFF_W-1:0];
				cmas_pkg::REG_CAL_GAIN:    cal_gain_q    <= pwdata[cmas_pkg::GAIN_W-1:0];
				cmas_pkg::REG_WINDOW_SIZE: window_size_q <= wsize_wr;
				default: ;
			endcase
		end
	end

	// calibration
	assign diff_c   = $signed({2'b00, raw_q}) - $signed({cal_offset_q[cmas_pkg::OFF_W-1],
		cal_offset_q});
	assign gain_eff = (cal_gain_q == '0) ? cmas_pkg::GAIN_ONE : {1'b0, cal_gain_q};
	assign gmul_c   = $signed({1'b0, gain_eff});
	assign prod_c   = diff_c * gmul_c;

	always_comb begin
		if (prod_q <= 0)
			val_c = '0;
		else if (|prod_q[cmas_pkg::PROD_W-1:cmas_pkg::RAW_W+8])
			val_c = cmas_pkg::RAW_MAX;
		else
			val_c = prod_q[cmas_pkg::RAW_W+7:8];
	end

	assign rnd_c = {1'b0, val_c} + cmas_pkg::ROUND_HALF;

	// ring bookkeeping
	assign wi_inc = CW'(wi_q) + 1'b1;
	assign wrap   = wi_inc == CW'(window_size_q);
	assign cnt_nx = (full_q | wrap) ? window_size_q : cmas_pkg::WSIZE_W'(wi_inc);
	assign store_we = (state_q == cmas_pkg::ST_CAL) && (window_size_q > cmas_pkg::WSIZE_W'(1));

	always_ff @(posedge clk) begin
		if (store_we)
			store[wi_q] <= val_c;
		rd_data_s1 <= store[rd_addr_q];
	end

	assign div_start = (state_q == cmas_pkg::ST_SUM) && (rem_q == '0) && !rd_vld_s1;

	cmas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign in_ready = state_q == cmas_pkg::ST_IDLE;
	assign out_load = (state_q == cmas_pkg::ST_OUT) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cmas_pkg::ST_IDLE;
			wi_q      <= '0;
			full_q    <= 1'b0;
			rem_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (cfg_wr && reg_idx == cmas_pkg::REG_WINDOW_SIZE) begin
				wi_q   <= '0;
				full_q <= 1'b0;
			end
			case (state_q)
				cmas_pkg::ST_IDLE: begin
					if (in_valid)
						state_q <= enable_q ? cmas_pkg::ST_MUL : cmas_pkg::ST_OUT;
				end
				cmas_pkg::ST_MUL: begin
					state_q <= cmas_pkg::ST_CAL;
				end
				cmas_pkg::ST_CAL: begin
					if (store_we) begin
						wi_q    <= wrap ? '0 : wi_inc[AW-1:0];
						full_q  <= full_q | wrap;
						rem_q   <= cnt_nx;
						state_q <= cmas_pkg::ST_SUM;
					end else begin
						state_q <= cmas_pkg::ST_OUT;
					end
				end
				cmas_pkg::ST_SUM: begin
					if (rem_q != '0) begin
						rem_q     <= rem_q - 1'b1;
						rd_vld_s1 <= 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= cmas_pkg::ST_DIV;
					end
				end
				cmas_pkg::ST_DIV: begin
					if (div_done)
						state_q <= cmas_pkg::ST_OUT;
				end
				cmas_pkg::ST_OUT: begin
					if (out_load)
						state_q <= cmas_pkg::ST_IDLE;
				end
				default: state_q <= cmas_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			cmas_pkg::ST_IDLE: begin
				raw_q      <= raw_reading;
				res_q      <= '0;
				res_stat_q <= 1'b1;
			end
			cmas_pkg::ST_MUL: begin
				prod_q <= prod_c;
			end
			cmas_pkg::ST_CAL: begin
				res_stat_q <= 1'b0;
				res_q      <= rnd_c[cmas_pkg::RAW_W] ? cmas_pkg::OUT_MAX
					: rnd_c[cmas_pkg::RAW_W-1:4];
				cnt_q      <= cnt_nx;
				sum_q      <= cmas_pkg::SUM_W'({cnt_nx, 3'b000});
				rd_addr_q  <= '0;
			end
			cmas_pkg::ST_SUM: begin
				if (rem_q != '0)
					rd_addr_q <= rd_addr_q + 1'b1;
				if (rd_vld_s1)
					sum_q <= sum_q + cmas_pkg::SUM_W'(rd_data_s1);
			end
			cmas_pkg::ST_DIV: begin
				if (div_done)
					res_q <= (|quo[cmas_pkg::SUM_W-1:cmas_pkg::OUT_W+4]) ? cmas_pkg::OUT_MAX
						: quo[cmas_pkg::OUT_W+3:4];
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ppfd_out_q <= res_q;
			status_q   <= res_stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ppfd_out  = ppfd_out_q;
	assign status    = status_q;

	// checks
	a_sum_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> cnt_q != '0)
		else $error("average started with empty window");

	a_not_init_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> ppfd_out_q == '0)
		else $error("not initialized item carries nonzero reading");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == cmas_pkg::ST_DIV)
		else $error("divider finished outside divide phase");

	a_ring_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		window_size_q > cmas_pkg::WSIZE_W'(1) |-> CW'(wi_q) < CW'(window_size_q))
		else $error("ring index beyond window size");

endmodule

/* hw/rtl/cmas_div.sv */
`timescale 1ns / 1ps

module cmas_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cmas_pkg::SUM_W-1:0]  dividend,
	input  logic [cmas_pkg::WSIZE_W-1:0] divisor,
	output logic                        done,
	output logic [cmas_pkg::SUM_W-1:0]  quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [cmas_pkg::DCNT_W-1:0]   cnt_q;
	logic [cmas_pkg::SUM_W-1:0]    dvd_q;
	logic [cmas_pkg::WSIZE_W-1:0]  rem_q;
	logic [cmas_pkg::WSIZE_W-1:0]  dsr_q;
	logic [cmas_pkg::WSIZE_W:0]    trial;
	logic [cmas_pkg::WSIZE_W:0]    diff;
	logic                          ge;

	// one restoring step per cycle, quotient bits shift in behind the dividend
	assign trial = {rem_q, dvd_q[cmas_pkg::SUM_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cmas_pkg::DCNT_W'(cmas_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[cmas_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? diff[cmas_pkg::WSIZE_W-1:0] : trial[cmas_pkg::WSIZE_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

/* test/calibrated_moving_average_sensor_top_test.sv */
`timescale 1ns / 1ps

module calibrated_moving_average_sensor_top_test;

	localparam int  RING_DEPTH      = 16;
	localparam int  CYCLE_LIMIT     = 1_000_000;
	localparam int  RANDOM_READINGS = 1826;
	localparam int  SETTLE_CYCLES   = 60;
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NOT_INIT = 1'b1;

	typedef enum logic {
		ACT_READ,
		ACT_CFG
	} act_t;

	typedef struct packed {
		act_t                        act;
		cmas_pkg::reg_idx_t          idx;
		logic [cmas_pkg::DATA_W-1:0] data;
		logic [cmas_pkg::RAW_W-1:0]  raw;
		logic                        known;
		logic [cmas_pkg::OUT_W-1:0]  ppfd;
		logic                        status;
	} script_row_t;

	typedef struct packed {
		logic [cmas_pkg::OUT_W-1:0] ppfd;
		logic                       status;
	} reading_result_t;

	localparam int SCRIPT_LEN = 37;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00000, 1'b1, 16'd0, STATUS_NOT_INIT},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'hFFFFF, 1'b1, 16'd0, STATUS_NOT_INIT},
		'{ACT_CFG, cmas_pkg::REG_ENABLE, 32'd1, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00000, 1'b1, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'hFFFFF, 1'b1, 16'd65535, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00008, 1'b1, 16'd1, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00007, 1'b1, 16'd0, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_CAL_OFFSET, 32'h0010_0000, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'hFFFFF, 1'b1, 16'd65535, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00000, 1'b1, 16'd65535, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_CAL_OFFSET, 32'h000F_FFFF, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00000, 1'b1, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'hFFFFF, 1'b1, 16'd0, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_CAL_OFFSET, 32'd0, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_CAL_GAIN, 32'h0000_FFFF, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00010, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'hFFFFF, 1'b1, 16'd65535, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_CAL_GAIN, 32'd1, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'hFFFFF, 1'b0, 16'd0, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_CAL_GAIN, 32'd0, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_WINDOW_SIZE, 32'd31, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h12345, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'hFFFFF, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00018, 1'b0, 16'd0, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_WINDOW_SIZE, 32'd2, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'hFFFFF, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00010, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'hABCDE, 1'b0, 16'd0, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_ENABLE, 32'd0, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h55555, 1'b1, 16'd0, STATUS_NOT_INIT},
		'{ACT_CFG, cmas_pkg::REG_ENABLE, 32'd1, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h00008, 1'b0, 16'd0, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_WINDOW_SIZE, 32'd0, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h0000F, 1'b0, 16'd0, STATUS_OK},
		'{ACT_CFG, cmas_pkg::REG_WINDOW_SIZE, 32'd1, 20'h00000, 1'b0, 16'd0, STATUS_OK},
		'{ACT_READ, cmas_pkg::REG_ENABLE, 32'd0, 20'h80000, 1'b0, 16'd0, STATUS_OK}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [cmas_pkg::ADDR_W-1:0] paddr;
	logic [cmas_pkg::DATA_W-1:0] pwdata;
	logic [cmas_pkg::DATA_W-1:0] prdata;
	logic                        pready;
	logic                        in_valid;
	logic                        in_ready;
	logic [cmas_pkg::RAW_W-1:0]  raw_reading;
	logic                        out_valid;
	logic                        out_ready;
	logic [cmas_pkg::OUT_W-1:0]  ppfd_out;
	logic                        status;

	// shadow of the calibration registers and the averaging ring
	logic                        sh_enable = 1'b0;
	logic [cmas_pkg::OFF_W-1:0]  sh_offset = '0;
	logic [cmas_pkg::GAIN_W-1:0] sh_gain   = '0;
	int                          sh_window = 1;
	logic [cmas_pkg::RAW_W-1:0]  ring_vals [RING_DEPTH];
	int                          ring_idx;
	bit                          ring_wrapped;

	reading_result_t   pending_results [$];
	reading_result_t   oldest;
	int                errors;
	int                cycles;
	bit                quiet;

	calibrated_moving_average_sensor_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.raw_reading (raw_reading),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ppfd_out    (ppfd_out),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_ring();
		for (int i = 0; i < RING_DEPTH; i++)
			ring_vals[i] = '0;
		ring_idx     = 0;
		ring_wrapped = 1'b0;
	endfunction

	function automatic void apply_reg(cmas_pkg::reg_idx_t idx,
			logic [cmas_pkg::DATA_W-1:0] data);
		case (idx)
			cmas_pkg::REG_ENABLE: begin
				sh_enable = data[0];
			end
			cmas_pkg::REG_CAL_OFFSET: begin
				sh_offset = data[cmas_pkg::OFF_W-1:0];
			end
			cmas_pkg::REG_CAL_GAIN: begin
				sh_gain = data[cmas_pkg::GAIN_W-1:0];
			end
			cmas_pkg::REG_WINDOW_SIZE: begin
				sh_window = (data[cmas_pkg::WSIZE_W-1:0] > RING_DEPTH) ? RING_DEPTH
					: int'(data[cmas_pkg::WSIZE_W-1:0]);
				clear_ring();
			end
			default: ;
		endcase
	endfunction

	function automatic reading_result_t calibrate_and_average(
			logic [cmas_pkg::RAW_W-1:0] raw);
		logic signed [cmas_pkg::PROD_W-1:0] diff;
		logic signed [cmas_pkg::PROD_W-1:0] prod;
		logic [cmas_pkg::GAIN_W:0]          gain;
		logic [cmas_pkg::RAW_W-1:0]         v;
		logic [31:0]                        sum;
		logic [31:0]                        avg;
		int                                 count;
		reading_result_t                    res;
		if (!sh_enable) begin
			res.ppfd   = '0;
			res.status = STATUS_NOT_INIT;
			return res;
		end
		gain = (sh_gain == '0) ? cmas_pkg::GAIN_ONE : {1'b0, sh_gain};
		diff = $signed({20'b0, raw})
			- $signed({{19{sh_offset[cmas_pkg::OFF_W-1]}}, sh_offset});
		prod = diff * $signed({23'b0, gain});
		if (prod <= 0)
			v = '0;
		else if (prod[cmas_pkg::PROD_W-1:8] > {12'b0, cmas_pkg::RAW_MAX})
			v = cmas_pkg::RAW_MAX;
		else
			v = prod[27:8];
		if (sh_window > 1) begin
			ring_vals[ring_idx] = v;
			ring_idx = (ring_idx + 1) % sh_window;
			if (ring_idx == 0)
				ring_wrapped = 1'b1;
			count = ring_wrapped ? sh_window : ring_idx;
			sum = '0;
			for (int i = 0; i < count; i++)
				sum = sum + {12'b0, ring_vals[i]};
			avg = (sum + 32'(count) * 8) / (32'(count) * 16);
		end else begin
			avg = ({12'b0, v} + 32'd8) >> 4;
		end
		res.ppfd   = (avg > {16'b0, cmas_pkg::OUT_MAX}) ? cmas_pkg::OUT_MAX
			: avg[cmas_pkg::OUT_W-1:0];
		res.status = STATUS_OK;
		return res;
	endfunction

	task automatic cfg_write(cmas_pkg::reg_idx_t idx, logic [cmas_pkg::DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_reg(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_reading(logic [cmas_pkg::RAW_W-1:0] raw, logic known,
			logic [cmas_pkg::OUT_W-1:0] ppfd, logic stat);
		reading_result_t res;
		@(negedge clk);
		if (!quiet && $urandom_range(199) < 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(40, 5)) @(negedge clk);
		end
		while (!quiet && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		raw_reading <= raw;
		do @(posedge clk); while (!in_ready);
		res = calibrate_and_average(raw);
		if (known) begin
			res.ppfd   = ppfd;
			res.status = stat;
		end
		pending_results.push_back(res);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [cmas_pkg::RAW_W-1:0] pick_raw();
		case ($urandom_range(9))
			0:       return cmas_pkg::RAW_MAX;
			1:       return '0;
			2, 3, 4: return cmas_pkg::RAW_W'($urandom_range(4095));
			default: return cmas_pkg::RAW_W'($urandom_range(cmas_pkg::RAW_MAX));
		endcase
	endfunction

	task automatic random_config();
		logic [cmas_pkg::OFF_W-1:0]  off;
		logic [cmas_pkg::DATA_W-1:0] gain;
		logic [cmas_pkg::DATA_W-1:0] win;
		if ($urandom_range(99) < 70) begin
			case ($urandom_range(4))
				0:       off = 21'h100000;
				1:       off = 21'h0FFFFF;
				2:       off = cmas_pkg::OFF_W'(int'($urandom_range(2047)) - 1024);
				default: off = cmas_pkg::OFF_W'($urandom);
			endcase
			cfg_write(cmas_pkg::REG_CAL_OFFSET, {11'b0, off});
		end
		if ($urandom_range(99) < 70) begin
			case ($urandom_range(5))
				0:       gain = 32'd0;
				1:       gain = 32'h0000_FFFF;
				2:       gain = 32'd1;
				3:       gain = $urandom_range(512, 128);
				default: gain = $urandom_range(16'hFFFF);
			endcase
			cfg_write(cmas_pkg::REG_CAL_GAIN, gain);
		end
		if ($urandom_range(99) < 60) begin
			case ($urandom_range(5))
				0:       win = 32'd0;
				1:       win = 32'd1;
				2:       win = 32'd16;
				3:       win = $urandom_range(31, 17);
				default: win = $urandom_range(16, 2);
			endcase
			cfg_write(cmas_pkg::REG_WINDOW_SIZE, win);
		end
		if ($urandom_range(99) < 40)
			cfg_write(cmas_pkg::REG_ENABLE, {31'b0, ($urandom_range(9) != 0)});
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(199) < 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(40, 5)) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= 31);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, ppfd_out %0d status %0d",
					$time, ppfd_out, status);
			end else begin
				oldest = pending_results.pop_front();
				if (ppfd_out !== oldest.ppfd) begin
					errors++;
					$display("%0t: ppfd_out expected %0d actual %0d",
						$time, oldest.ppfd, ppfd_out);
				end
				if (status !== oldest.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d",
						$time, oldest.status, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int sent;
		int batch;
		errors      = 0;
		cycles      = 0;
		quiet       = 1'b0;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		raw_reading = '0;
		clear_ring();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < SCRIPT_LEN; k++) begin
			if (SCRIPT[k].act == ACT_CFG) begin
				wait_idle();
				cfg_write(SCRIPT[k].idx, SCRIPT[k].data);
			end else begin
				send_reading(SCRIPT[k].raw, SCRIPT[k].known, SCRIPT[k].ppfd,
					SCRIPT[k].status);
			end
		end

		sent = 0;
		while (sent < RANDOM_READINGS) begin
			wait_idle();
			random_config();
			quiet = (sent >= 700 && sent < 1000);
			batch = $urandom_range(120, 20);
			if (batch > RANDOM_READINGS - sent)
				batch = RANDOM_READINGS - sent;
			for (int n = 0; n < batch; n++) begin
				send_reading(pick_raw(), 1'b0, '0, STATUS_OK);
				sent++;
			end
		end
		quiet = 1'b0;

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
